@@ rtl/core/joystick_differential_drive_mixer_defines.svh @@
// Assertion macros used by the sequencer of the joystick drive mixer RTL.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JDDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jddm assertion failed");

// Next-cycle implication, checked out of reset.
`define JDDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jddm assertion failed");

`endif

@@ rtl/core/jddm_pkg.sv @@
// Types, constants and helpers of the joystick drive mixer.
`default_nettype none
package jddm_pkg;

    localparam logic [7:0]  HDR_X = 8'h11;
    localparam logic [7:0]  HDR_Y = 8'h21;

    localparam logic [9:0]        CENTER_RST = 10'd512;
    localparam logic [7:0]        DEAD_RST   = 8'd20;
    localparam logic signed [8:0] TRIM_RST   = 9'sd70;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_DEAD   = 2'd1;
    localparam logic [1:0] REG_TRIM   = 2'd2;

    // rotation: |v| * 707, then /1000 through a reciprocal
    localparam logic [9:0]  ROT_MUL    = 10'd707;
    localparam logic [20:0] DIV1000_K  = 21'd1073742;
    localparam int          DIV1000_SH = 30;

    // mapping: floor((r + 723) * 85 / 241), offset by 256 * 241 to stay positive
    localparam logic signed [18:0] MAP_IN_OFS = 19'sd723;
    localparam logic signed [18:0] MAP_MUL    = 19'sd85;
    localparam logic signed [18:0] MAP_POS    = 19'sd61696;
    localparam logic [18:0]        MAP_K      = 19'd278461;
    localparam int                 MAP_SH     = 26;
    localparam logic signed [10:0] MAP_BIAS   = 11'sd511;

    typedef enum logic [2:0] {
        POS_HDR_X = 3'd0,
        POS_X_LO  = 3'd1,
        POS_X_HI  = 3'd2,
        POS_HDR_Y = 3'd3,
        POS_Y_LO  = 3'd4,
        POS_Y_HI  = 3'd5
    } t_pos;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_DIV,
        ST_MAP,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic rot_en;
        logic div_en;
        logic map_en;
        logic scale_en;
        logic load_drive;
    } t_cmd;

    typedef struct packed {
        logic last_pos;
        logic hdr_pos;
        logic out_valid;
        logic out_free;
    } t_sts;

    function automatic logic [9:0] clamp10(input logic [7:0] lo, input logic [7:0] hi);
        logic [9:0] v;
        v = (|hi[7:2]) ? 10'h3FF : {hi[1:0], lo};
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/joystick_differential_drive_mixer.sv @@
// Top level of the joystick drive mixer: register port, sequencer and datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   rx in    | i_rx_valid / o_rx_ready    | i_rx_byte
//   drive out| o_drv_valid / i_drv_ready  | o_duty_x o_forward_x o_duty_y o_forward_y
//            |                            | o_stopped
//   config   | psel penable pwrite pready | paddr pwdata prdata
//
// Bytes are taken while the sequencer is idle; the last byte of a frame starts the
// five-step mixing sequence (four single-multiply steps in each lane, then the load).
// A finished item waits in the output register; data bytes are still taken meanwhile,
// header bytes wait until the register is free.
// Reset (synchronous, active low) clears the parser, the sequencer and the registers
// to center 512, dead zone 20, trim 70.
`default_nettype none
module joystick_differential_drive_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_drv_valid,
    input  wire logic        i_drv_ready,
    output logic [7:0]       o_duty_x,
    output logic             o_forward_x,
    output logic [7:0]       o_duty_y,
    output logic             o_forward_y,
    output logic             o_stopped
);

    logic [9:0]        r_center;
    logic [7:0]        r_dead;
    logic signed [8:0] r_trim;

    jddm_pkg::t_cmd w_cmd;
    jddm_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= jddm_pkg::CENTER_RST;
            r_dead   <= jddm_pkg::DEAD_RST;
            r_trim   <= jddm_pkg::TRIM_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                jddm_pkg::REG_CENTER: r_center <= pwdata[9:0];
                jddm_pkg::REG_DEAD:   r_dead   <= pwdata[7:0];
                jddm_pkg::REG_TRIM:   r_trim   <= $signed(pwdata[8:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            jddm_pkg::REG_CENTER: prdata = {22'd0, r_center};
            jddm_pkg::REG_DEAD:   prdata = {24'd0, r_dead};
            jddm_pkg::REG_TRIM:   prdata = {23'd0, r_trim};
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    jddm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    jddm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rx_byte   (i_rx_byte),
        .i_center    (r_center),
        .i_dead      (r_dead),
        .i_trim      (r_trim),
        .i_drv_ready (i_drv_ready),
        .o_drv_valid (o_drv_valid),
        .o_duty_x    (o_duty_x),
        .o_forward_x (o_forward_x),
        .o_duty_y    (o_duty_y),
        .o_forward_y (o_forward_y),
        .o_stopped   (o_stopped)
    );

endmodule
`default_nettype wire

@@ rtl/core/jddm_ctrl.sv @@
// Sequencer of the joystick drive mixer: byte intake and the mixing steps.
`default_nettype none
`include "joystick_differential_drive_mixer_defines.svh"
module jddm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire jddm_pkg::t_sts i_sts,
    output jddm_pkg::t_cmd     o_cmd
);

    jddm_pkg::t_state r_state;
    jddm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jddm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b0;
        unique case (r_state)
            jddm_pkg::ST_IDLE: begin
                // a header byte may give a stop item: hold it off while the slot is full
                o_rx_ready = !i_sts.out_valid || !i_sts.hdr_pos;
                o_cmd.take = i_rx_valid && o_rx_ready;
                if (o_cmd.take && i_sts.last_pos) begin
                    n_state = jddm_pkg::ST_ROT;
                end
            end
            jddm_pkg::ST_ROT: begin
                o_cmd.rot_en = 1'b1;
                n_state      = jddm_pkg::ST_DIV;
            end
            jddm_pkg::ST_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state      = jddm_pkg::ST_MAP;
            end
            jddm_pkg::ST_MAP: begin
                o_cmd.map_en = 1'b1;
                n_state      = jddm_pkg::ST_SCALE;
            end
            jddm_pkg::ST_SCALE: begin
                o_cmd.scale_en = 1'b1;
                n_state        = jddm_pkg::ST_OUT;
            end
            jddm_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_drive = 1'b1;
                    n_state          = jddm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jddm_pkg::ST_IDLE;
            end
        endcase
    end

    `JDDM_ASSERT_NXT(a_frame_starts_mix, i_clk, i_rst_n, o_cmd.take && i_sts.last_pos, r_state == jddm_pkg::ST_ROT)
    `JDDM_ASSERT_IMP(a_load_needs_slot, i_clk, i_rst_n, o_cmd.load_drive, i_sts.out_free)
    `JDDM_ASSERT_IMP(a_hdr_needs_empty, i_clk, i_rst_n, o_cmd.take && i_sts.hdr_pos, !i_sts.out_valid)

endmodule
`default_nettype wire

@@ rtl/core/jddm_axis.sv @@
// One mixing lane: rotate, rescale, trim, dead zone and sign-magnitude drive.
`default_nettype none
module jddm_axis (
    input  wire logic               i_clk,
    input  wire jddm_pkg::t_cmd     i_cmd,
    input  wire logic signed [11:0] i_rot,
    input  wire logic signed [8:0]  i_trim,
    input  wire logic [7:0]         i_dead,
    output logic [7:0]              o_duty,
    output logic                    o_fwd
);

    logic                r_neg;
    logic [20:0]         r_prod;
    logic [10:0]         r_q;
    logic [17:0]         r_np;
    logic signed [10:0]  r_m;

    logic [11:0]         w_mag;
    logic [20:0]         w_prod;
    logic [41:0]         w_div;
    logic signed [11:0]  w_rot;
    logic signed [18:0]  w_np;
    logic [36:0]         w_sc;
    logic [9:0]          w_q2;
    logic signed [10:0]  w_dz;
    logic signed [10:0]  w_m;
    logic [10:0]         w_abs;

    always_comb begin
        w_mag  = i_rot[11] ? 12'(-i_rot) : 12'(i_rot);
        w_prod = {10'd0, w_mag[10:0]} * {11'd0, jddm_pkg::ROT_MUL};
        w_div  = {21'd0, r_prod} * {21'd0, jddm_pkg::DIV1000_K};
        w_rot  = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        w_np   = (19'(w_rot) + jddm_pkg::MAP_IN_OFS) * jddm_pkg::MAP_MUL + jddm_pkg::MAP_POS;
        w_sc   = {19'd0, r_np} * {18'd0, jddm_pkg::MAP_K};
        w_q2   = w_sc[jddm_pkg::MAP_SH +: 10];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_en) begin
            r_neg  <= i_rot[11];
            r_prod <= w_prod;
        end
        if (i_cmd.div_en) begin
            r_q <= w_div[jddm_pkg::DIV1000_SH +: 11];
        end
        if (i_cmd.map_en) begin
            r_np <= w_np[17:0];
        end
        if (i_cmd.scale_en) begin
            r_m <= $signed({1'b0, w_q2}) - jddm_pkg::MAP_BIAS + 11'(i_trim);
        end
    end

    always_comb begin
        w_dz = $signed({3'b000, i_dead});
        if (r_m < w_dz && r_m > -w_dz) begin
            w_m = '0;
        end else begin
            w_m = r_m;
        end
        w_abs  = w_m[10] ? 11'(-w_m) : 11'(w_m);
        o_duty = (|w_abs[10:8]) ? 8'hFF : w_abs[7:0];
        o_fwd  = !w_m[10] && (|w_m);
    end

endmodule
`default_nettype wire

@@ rtl/core/jddm_dp.sv @@
// Datapath of the joystick drive mixer: frame parser, two lanes, output register.
`default_nettype none
module jddm_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jddm_pkg::t_cmd    i_cmd,
    output jddm_pkg::t_sts         o_sts,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [9:0]        i_center,
    input  wire logic [7:0]        i_dead,
    input  wire logic signed [8:0] i_trim,
    input  wire logic              i_drv_ready,
    output logic                   o_drv_valid,
    output logic [7:0]             o_duty_x,
    output logic                   o_forward_x,
    output logic [7:0]             o_duty_y,
    output logic                   o_forward_y,
    output logic                   o_stopped
);

    jddm_pkg::t_pos     r_pos;
    jddm_pkg::t_pos     n_pos;
    logic [7:0]         r_low;
    logic [9:0]         r_x;
    logic signed [11:0] r_sum;
    logic signed [11:0] r_diff;
    logic               r_out_valid;
    logic [7:0]         r_duty_x;
    logic               r_fwd_x;
    logic [7:0]         r_duty_y;
    logic               r_fwd_y;
    logic               r_stopped;

    logic               n_bad;
    logic [9:0]         w_y;
    logic [7:0]         w_duty_x;
    logic               w_fwd_x;
    logic [7:0]         w_duty_y;
    logic               w_fwd_y;

    always_comb begin
        n_pos = r_pos;
        n_bad = 1'b0;
        unique case (r_pos)
            jddm_pkg::POS_HDR_X: begin
                n_bad = (i_rx_byte != jddm_pkg::HDR_X);
                n_pos = n_bad ? jddm_pkg::POS_HDR_X : jddm_pkg::POS_X_LO;
            end
            jddm_pkg::POS_X_LO:  n_pos = jddm_pkg::POS_X_HI;
            jddm_pkg::POS_X_HI:  n_pos = jddm_pkg::POS_HDR_Y;
            jddm_pkg::POS_HDR_Y: begin
                n_bad = (i_rx_byte != jddm_pkg::HDR_Y);
                n_pos = n_bad ? jddm_pkg::POS_HDR_X : jddm_pkg::POS_Y_LO;
            end
            jddm_pkg::POS_Y_LO:  n_pos = jddm_pkg::POS_Y_HI;
            jddm_pkg::POS_Y_HI:  n_pos = jddm_pkg::POS_HDR_X;
            default:             n_pos = jddm_pkg::POS_HDR_X;
        endcase
        w_y = jddm_pkg::clamp10(r_low, i_rx_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= jddm_pkg::POS_HDR_X;
            r_low <= '0;
            r_x   <= '0;
        end else if (i_cmd.take) begin
            r_pos <= n_pos;
            if (r_pos == jddm_pkg::POS_X_LO || r_pos == jddm_pkg::POS_Y_LO) begin
                r_low <= i_rx_byte;
            end
            if (r_pos == jddm_pkg::POS_X_HI) begin
                r_x <= jddm_pkg::clamp10(r_low, i_rx_byte);
            end
        end
    end

    // x lane sees dx + dy = x - y, y lane sees dy - dx = 2c - x - y
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_pos == jddm_pkg::POS_Y_HI) begin
            r_sum  <= $signed({2'b00, r_x}) - $signed({2'b00, w_y});
            r_diff <= $signed({1'b0, i_center, 1'b0}) - $signed({2'b00, r_x})
                      - $signed({2'b00, w_y});
        end
    end

    jddm_axis u_axis_x (
        .i_clk  (i_clk),
        .i_cmd  (i_cmd),
        .i_rot  (r_sum),
        .i_trim ('0),
        .i_dead (i_dead),
        .o_duty (w_duty_x),
        .o_fwd  (w_fwd_x)
    );

    jddm_axis u_axis_y (
        .i_clk  (i_clk),
        .i_cmd  (i_cmd),
        .i_rot  (r_diff),
        .i_trim (i_trim),
        .i_dead (i_dead),
        .o_duty (w_duty_y),
        .o_fwd  (w_fwd_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_drive || (i_cmd.take && n_bad)) begin
            r_out_valid <= 1'b1;
        end else if (i_drv_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_drive) begin
            r_duty_x  <= w_duty_x;
            r_fwd_x   <= w_fwd_x;
            r_duty_y  <= w_duty_y;
            r_fwd_y   <= w_fwd_y;
            r_stopped <= 1'b0;
        end else if (i_cmd.take && n_bad) begin
            r_duty_x  <= '0;
            r_fwd_x   <= 1'b0;
            r_duty_y  <= '0;
            r_fwd_y   <= 1'b0;
            r_stopped <= 1'b1;
        end
    end

    always_comb begin
        o_sts.last_pos  = (r_pos == jddm_pkg::POS_Y_HI);
        o_sts.hdr_pos   = (r_pos == jddm_pkg::POS_HDR_X) || (r_pos == jddm_pkg::POS_HDR_Y);
        o_sts.out_valid = r_out_valid;
        o_sts.out_free  = !r_out_valid || i_drv_ready;
    end

    assign o_drv_valid = r_out_valid;
    assign o_duty_x    = r_duty_x;
    assign o_forward_x = r_fwd_x;
    assign o_duty_y    = r_duty_y;
    assign o_forward_y = r_fwd_y;
    assign o_stopped   = r_stopped;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for the joystick drive mixer: framed bytes in, drive items checked against a predictor.
`default_nettype none
module testbench;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 20;
    localparam int TARGET_BYTES = 1250;

    typedef struct packed {
        logic [7:0] duty_x;
        logic       forward_x;
        logic [7:0] duty_y;
        logic       forward_y;
        logic       stopped;
    } t_drive;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY_FIFTH,
        SINK_RARE
    } t_sink_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_drv_valid;
    logic        i_drv_ready = 1'b0;
    logic [7:0]  o_duty_x;
    logic        o_forward_x;
    logic [7:0]  o_duty_y;
    logic        o_forward_y;
    logic        o_stopped;

    logic [9:0]        center;
    logic [7:0]        dead_zone;
    logic signed [8:0] y_trim;
    jddm_pkg::t_pos    frame_pos;
    logic [7:0]        low_byte;
    logic [9:0]        x_value;

    t_drive     expected_drive[$];
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left = 0;
    int         burst_left;
    int         cycles = 0;
    int         errors;
    int         bytes_sent;
    int         drive_seen;
    int         stops_seen;
    int         reg_writes;

    joystick_differential_drive_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_drv_valid (o_drv_valid),
        .i_drv_ready (i_drv_ready),
        .o_duty_x    (o_duty_x),
        .o_forward_x (o_forward_x),
        .o_duty_y    (o_duty_y),
        .o_forward_y (o_forward_y),
        .o_stopped   (o_stopped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [9:0] axis_value(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] v;
        v = {hi, lo};
        return (v > 16'd1023) ? 10'd1023 : v[9:0];
    endfunction

    function automatic int mix_axis(input int r, input int trim);
        int num;
        int m;
        num = (r + 723) * 510;
        m = num / 1446;
        if (num % 1446 != 0 && num < 0) begin
            m = m - 1;
        end
        m = m - 255 + trim;
        if (m < int'(dead_zone) && m > -int'(dead_zone)) begin
            m = 0;
        end
        return m;
    endfunction

    function automatic logic [7:0] duty_of(input int m);
        int mag;
        mag = (m > 0) ? m : -m;
        if (mag > 255) begin
            mag = 255;
        end
        return mag[7:0];
    endfunction

    function automatic bit predict_drive(input logic [7:0] b, output t_drive res);
        int dx;
        int dy;
        int rx;
        int ry;
        int mx;
        int my;
        res = '0;
        res.stopped = 1'b1;
        case (frame_pos)
            jddm_pkg::POS_HDR_X: begin
                if (b != jddm_pkg::HDR_X) begin
                    return 1'b1;
                end
                frame_pos = jddm_pkg::POS_X_LO;
            end
            jddm_pkg::POS_X_LO: begin
                low_byte = b;
                frame_pos = jddm_pkg::POS_X_HI;
            end
            jddm_pkg::POS_X_HI: begin
                x_value = axis_value(low_byte, b);
                frame_pos = jddm_pkg::POS_HDR_Y;
            end
            jddm_pkg::POS_HDR_Y: begin
                if (b != jddm_pkg::HDR_Y) begin
                    frame_pos = jddm_pkg::POS_HDR_X;
                    return 1'b1;
                end
                frame_pos = jddm_pkg::POS_Y_LO;
            end
            jddm_pkg::POS_Y_LO: begin
                low_byte = b;
                frame_pos = jddm_pkg::POS_Y_HI;
            end
            jddm_pkg::POS_Y_HI: begin
                dx = int'(x_value) - int'(center);
                dy = int'(center) - int'(axis_value(low_byte, b));
                rx = ((dx + dy) * 707) / 1000;
                ry = ((dy - dx) * 707) / 1000;
                mx = mix_axis(rx, 0);
                my = mix_axis(ry, int'(y_trim));
                res.duty_x    = duty_of(mx);
                res.forward_x = (mx > 0);
                res.duty_y    = duty_of(my);
                res.forward_y = (my > 0);
                res.stopped   = 1'b0;
                frame_pos = jddm_pkg::POS_HDR_X;
                return 1'b1;
            end
            default: begin
                frame_pos = jddm_pkg::POS_HDR_X;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        t_drive res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
        if (predict_drive(b, res)) begin
            expected_drive.push_back(res);
        end
    endtask

    task automatic send_frame(input logic [15:0] x, input logic [15:0] y);
        send_byte(jddm_pkg::HDR_X);
        send_byte(x[7:0]);
        send_byte(x[15:8]);
        send_byte(jddm_pkg::HDR_Y);
        send_byte(y[7:0]);
        send_byte(y[15:8]);
    endtask

    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            jddm_pkg::REG_CENTER: center    = val[9:0];
            jddm_pkg::REG_DEAD:   dead_zone = val[7:0];
            jddm_pkg::REG_TRIM:   y_trim    = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [9:0] c, input logic [7:0] d,
                                  input logic signed [8:0] t);
        wait_idle();
        write_reg(jddm_pkg::REG_CENTER, {22'd0, c});
        write_reg(jddm_pkg::REG_DEAD, {24'd0, d});
        write_reg(jddm_pkg::REG_TRIM, {23'd0, t});
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1023;
            2: return 16'($urandom);
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic test_frame_decode();
        send_frame(16'd512, 16'd512);
        send_frame(16'h1121, 16'h0000);
        send_frame(16'h0000, 16'hFFFF);
    endtask

    task automatic test_bad_headers();
        send_byte(jddm_pkg::HDR_Y);
        send_byte(jddm_pkg::HDR_X);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(jddm_pkg::HDR_X);
    endtask

    task automatic test_register_sweep();
        apply_settings(10'd1023, 8'd0, 9'sd255);
        repeat (4) send_frame(pick_axis(), pick_axis());
        apply_settings(10'd0, 8'd255, -9'sd255);
        repeat (4) send_frame(pick_axis(), pick_axis());
        apply_settings(10'd512, 8'd0, -9'sd1);
        repeat (4) send_frame(pick_axis(), pick_axis());
        apply_settings(10'd0, 8'd1, 9'sd0);
        repeat (4) send_frame(pick_axis(), pick_axis());
        apply_settings(jddm_pkg::CENTER_RST, jddm_pkg::DEAD_RST, jddm_pkg::TRIM_RST);
        repeat (4) send_frame(pick_axis(), pick_axis());
    endtask

    task automatic test_random_traffic();
        int since_cfg;
        int k;
        logic [15:0] x;
        logic [7:0] b;
        since_cfg = 0;
        while (bytes_sent < TARGET_BYTES) begin
            if (since_cfg > 150) begin
                apply_settings(($urandom_range(0, 3) == 0) ? 10'(1023 * $urandom_range(0, 1))
                                                           : 10'($urandom_range(0, 1023)),
                               8'($urandom_range(0, 255)),
                               9'($urandom_range(0, 510) - 255));
                since_cfg = 0;
            end
            k = bytes_sent;
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom));
                1: begin
                    x = pick_axis();
                    send_byte(jddm_pkg::HDR_X);
                    send_byte(x[7:0]);
                    send_byte(x[15:8]);
                    b = 8'($urandom);
                    if (b == jddm_pkg::HDR_Y) begin
                        b[0] = ~b[0];
                    end
                    send_byte(b);
                end
                default: send_frame(pick_axis(), pick_axis());
            endcase
            since_cfg += bytes_sent - k;
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:        i_drv_ready <= 1'b1;
            SINK_COIN:        i_drv_ready <= 1'($urandom_range(0, 1));
            SINK_EVERY_FIFTH: i_drv_ready <= (cycles % 5 == 0);
            SINK_RARE:        i_drv_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : drive_check
        t_drive got;
        t_drive want;
        if (i_rst_n && o_drv_valid && i_drv_ready) begin
            got = '{duty_x: o_duty_x, forward_x: o_forward_x, duty_y: o_duty_y,
                    forward_y: o_forward_y, stopped: o_stopped};
            if (expected_drive.size() == 0) begin
                $display("%0t unexpected item expected none actual %h", $time, got);
                errors++;
            end else begin
                want = expected_drive.pop_front();
                if (got !== want) begin
                    report_field("duty_x", int'(want.duty_x), int'(got.duty_x));
                    report_field("forward_x", int'(want.forward_x), int'(got.forward_x));
                    report_field("duty_y", int'(want.duty_y), int'(got.duty_y));
                    report_field("forward_y", int'(want.forward_y), int'(got.forward_y));
                    report_field("stopped", int'(want.stopped), int'(got.stopped));
                    if ($isunknown(got)) begin
                        $display("%0t unknown bits expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
                if (want.stopped) begin
                    stops_seen++;
                end else begin
                    drive_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_rx_valid  <= 1'b0;
        i_rx_byte   <= '0;
        burst_left  = 0;
        errors      = 0;
        bytes_sent  = 0;
        drive_seen  = 0;
        stops_seen  = 0;
        reg_writes  = 0;
        center      = jddm_pkg::CENTER_RST;
        dead_zone   = jddm_pkg::DEAD_RST;
        y_trim      = jddm_pkg::TRIM_RST;
        frame_pos   = jddm_pkg::POS_HDR_X;
        low_byte    = '0;
        x_value     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_decode();
        test_bad_headers();
        test_register_sweep();
        test_random_traffic();
        wait_idle();

        $display("sent %0d bytes, checked %0d drive items and %0d stop items",
                 bytes_sent, drive_seen, stops_seen);
        $display("made %0d register writes across extreme and random settings", reg_writes);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
